@@ sv/hic_pkg.sv @@
package hic_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W = 5;
   localparam int CORDIC_W = 28;
   localparam int DIFF_W = 17;
   localparam int MAG_W = 16;
   localparam int HEAD_W = 12;
   localparam int ANG_W = 32;
   localparam int PROD_W = 44;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   localparam logic [ANG_W-1:0] HALF_TURN = 32'h8000_0000;
   localparam logic [PROD_W:0] ROUND_HALF = 45'h0_8000_0000;
   localparam logic [11:0] DEG_SCALE = 12'd3600;

   localparam logic [HEAD_W-1:0] HEAD_EAST = 12'd0;
   localparam logic [HEAD_W-1:0] HEAD_NORTH = 12'd900;
   localparam logic [HEAD_W-1:0] HEAD_WEST = 12'd1800;
   localparam logic [HEAD_W-1:0] HEAD_SOUTH = 12'd2700;
   localparam logic [HEAD_W-1:0] HEAD_MAX = 12'd3600;

   typedef struct packed {
      logic calibrating;
      logic signed [MAG_W-1:0] offset_x;
      logic signed [MAG_W-1:0] offset_y;
   } cal_status_type;

   typedef struct packed {
      logic load;
      logic [1:0] kind;
      logic signed [MAG_W-1:0] mag_x;
      logic signed [MAG_W-1:0] mag_y;
   } cal_event_type;

   function automatic logic [ANG_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [ANG_W-1:0] val;
      case (idx)
         5'd0: val = 32'd536870912;
         5'd1: val = 32'd316933406;
         5'd2: val = 32'd167458907;
         5'd3: val = 32'd85004756;
         5'd4: val = 32'd42667331;
         5'd5: val = 32'd21354465;
         5'd6: val = 32'd10679838;
         5'd7: val = 32'd5340245;
         5'd8: val = 32'd2670163;
         5'd9: val = 32'd1335087;
         5'd10: val = 32'd667544;
         5'd11: val = 32'd333772;
         5'd12: val = 32'd166886;
         5'd13: val = 32'd83443;
         5'd14: val = 32'd41722;
         5'd15: val = 32'd20861;
         5'd16: val = 32'd10430;
         5'd17: val = 32'd5215;
         5'd18: val = 32'd2608;
         5'd19: val = 32'd1304;
         5'd20: val = 32'd652;
         5'd21: val = 32'd326;
         5'd22: val = 32'd163;
         5'd23: val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ sv/hic_cal.sv @@
module hic_cal (
   input  logic                   clock,
   input  logic                   reset,
   input  hic_pkg::cal_event_type evt,
   output hic_pkg::cal_status_type status
);
   import hic_pkg::*;

   logic calibrating_ff, calibrating_in;
   logic signed [MAG_W-1:0] x_lo_ff, x_lo_in, x_hi_ff, x_hi_in;
   logic signed [MAG_W-1:0] y_lo_ff, y_lo_in, y_hi_ff, y_hi_in;
   logic signed [MAG_W-1:0] off_x_ff, off_x_in, off_y_ff, off_y_in;
   logic signed [DIFF_W-1:0] sum_x, sum_y, half_x, half_y;

   always_comb begin
      sum_x = {x_hi_ff[MAG_W-1], x_hi_ff} + {x_lo_ff[MAG_W-1], x_lo_ff};
      sum_y = {y_hi_ff[MAG_W-1], y_hi_ff} + {y_lo_ff[MAG_W-1], y_lo_ff};
      // Adding the sign bit before the arithmetic shift makes the halving truncate toward zero.
      half_x = (sum_x + DIFF_W'(sum_x[DIFF_W-1])) >>> 1;
      half_y = (sum_y + DIFF_W'(sum_y[DIFF_W-1])) >>> 1;
   end

   always_comb begin
      calibrating_in = calibrating_ff;
      x_lo_in = x_lo_ff;
      x_hi_in = x_hi_ff;
      y_lo_in = y_lo_ff;
      y_hi_in = y_hi_ff;
      off_x_in = off_x_ff;
      off_y_in = off_y_ff;
      if (evt.load) begin
         unique case (evt.kind)
            KIND_SAMPLE: begin
               if (calibrating_ff) begin
                  if (evt.mag_x > x_hi_ff) x_hi_in = evt.mag_x;
                  if (evt.mag_x < x_lo_ff) x_lo_in = evt.mag_x;
                  if (evt.mag_y > y_hi_ff) y_hi_in = evt.mag_y;
                  if (evt.mag_y < y_lo_ff) y_lo_in = evt.mag_y;
               end
            end
            KIND_START: begin
               x_lo_in = '0;
               x_hi_in = '0;
               y_lo_in = '0;
               y_hi_in = '0;
               calibrating_in = 1'b1;
            end
            KIND_FINISH: begin
               off_x_in = half_x[MAG_W-1:0];
               off_y_in = half_y[MAG_W-1:0];
               calibrating_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calibrating_ff <= 1'b0;
         x_lo_ff <= '0;
         x_hi_ff <= '0;
         y_lo_ff <= '0;
         y_hi_ff <= '0;
         off_x_ff <= '0;
         off_y_ff <= '0;
      end else begin
         calibrating_ff <= calibrating_in;
         x_lo_ff <= x_lo_in;
         x_hi_ff <= x_hi_in;
         y_lo_ff <= y_lo_in;
         y_hi_ff <= y_hi_in;
         off_x_ff <= off_x_in;
         off_y_ff <= off_y_in;
      end
   end

   assign status.calibrating = calibrating_ff;
   assign status.offset_x = off_x_ff;
   assign status.offset_y = off_y_ff;

endmodule

@@ sv/hic_cordic.sv @@
module hic_cordic #(
   parameter int CORDIC_STEPS = hic_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [hic_pkg::DIFF_W-1:0]    dx,
   input  logic signed [hic_pkg::DIFF_W-1:0]    dy,
   output logic                                 done,
   output logic [hic_pkg::HEAD_W-1:0]           heading
);
   import hic_pkg::*;

   localparam int STEP_W = $clog2(CORDIC_STEPS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

   typedef enum logic [3:0] {
      CS_IDLE = 4'b0001,
      CS_ITER = 4'b0010,
      CS_MUL  = 4'b0100,
      CS_RND  = 4'b1000
   } cstate_type;

   cstate_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic done_ff, done_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [ANG_W-1:0] ang_ff, ang_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [HEAD_W-1:0] head_ff, head_in;

   logic signed [CORDIC_W-1:0] dx_s, dy_s, sx, sy;
   logic [ANG_W-1:0] atan_val;
   logic [PROD_W:0] rounded;
   logic [HEAD_W:0] turn_t;

   always_comb begin
      dx_s = {{(CORDIC_W-DIFF_W-8){dx[DIFF_W-1]}}, dx, 8'b0};
      dy_s = {{(CORDIC_W-DIFF_W-8){dy[DIFF_W-1]}}, dy, 8'b0};
      sx = x_ff >>> step_ff;
      sy = y_ff >>> step_ff;
      atan_val = atan_turn(ATAN_IDX_W'(step_ff));
      rounded = {1'b0, prod_ff} + ROUND_HALF;
      turn_t = rounded[PROD_W:ANG_W];
   end

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      done_in = 1'b0;
      x_in = x_ff;
      y_in = y_ff;
      ang_in = ang_ff;
      prod_in = prod_ff;
      head_in = head_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (start) begin
               step_in = '0;
               if (dy == '0) begin
                  head_in = dx[DIFF_W-1] ? HEAD_WEST : HEAD_EAST;
                  done_in = 1'b1;
               end else if (dx == '0) begin
                  head_in = dy[DIFF_W-1] ? HEAD_SOUTH : HEAD_NORTH;
                  done_in = 1'b1;
               end else begin
                  x_in = dx[DIFF_W-1] ? -dx_s : dx_s;
                  y_in = dx[DIFF_W-1] ? -dy_s : dy_s;
                  ang_in = dx[DIFF_W-1] ? HALF_TURN : '0;
                  state_in = CS_ITER;
               end
            end
         end
         CS_ITER: begin
            if (y_ff[CORDIC_W-1]) begin
               x_in = x_ff - sy;
               y_in = y_ff + sx;
               ang_in = ang_ff - atan_val;
            end else begin
               x_in = x_ff + sy;
               y_in = y_ff - sx;
               ang_in = ang_ff + atan_val;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) state_in = CS_MUL;
         end
         CS_MUL: begin
            prod_in = PROD_W'(ang_ff) * PROD_W'(DEG_SCALE);
            state_in = CS_RND;
         end
         CS_RND: begin
            head_in = (turn_t > {1'b0, HEAD_MAX}) ? HEAD_MAX : turn_t[HEAD_W-1:0];
            done_in = 1'b1;
            state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      x_ff <= x_in;
      y_ff <= y_in;
      ang_ff <= ang_in;
      prod_ff <= prod_in;
      head_ff <= head_in;
   end

   assign done = done_ff;
   assign heading = head_ff;

endmodule

@@ sv/compass_heading_hard_iron_cal_core.sv @@
// Compass heading with hard-iron calibration.
// Each request beat carries a kind code and one X/Y magnetometer sample. A start
// beat clears the stored extremes and enters calibration, samples taken during
// calibration widen the extremes, and a finish beat commits the midpoints as
// offsets. Any other sample has the offsets removed and its heading found by an
// iterative CORDIC unit, returned in tenths of a degree with heading_valid set.
// Every request beat yields exactly one response beat carrying the offsets in use.
// Events and calibration samples pass through the emit state into the response
// register; samples on an axis get their heading directly from the CORDIC unit
// without rotating, and other samples pass through the one rotation stage that
// serves every step, followed by the degree scaling multiply and rounding.
// One request is in flight at a time, so req_ready is low from acceptance until
// the result has moved into the response register, and the next request can be
// accepted once it has.
// A response that the receiver stalls holds in the response register; a new
// request may be accepted meanwhile, and its result waits until the register frees.
// Reset clears calibration, the extremes and the offsets to zero and empties
// the response register.
module compass_heading_hard_iron_cal_core #(
   parameter int CORDIC_STEPS = hic_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_kind,
   input  logic signed [hic_pkg::MAG_W-1:0]  req_mag_x,
   input  logic signed [hic_pkg::MAG_W-1:0]  req_mag_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [hic_pkg::HEAD_W-1:0]        rsp_heading_tenths,
   output logic                              rsp_heading_valid,
   output logic signed [hic_pkg::MAG_W-1:0]  rsp_offset_x_out,
   output logic signed [hic_pkg::MAG_W-1:0]  rsp_offset_y_out
);
   import hic_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic hv_ff, hv_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic hvalid_ff, hvalid_in;
   logic signed [MAG_W-1:0] offx_ff, offx_in, offy_ff, offy_in;

   logic accept, need_head, load_rsp, cordic_done;
   logic signed [DIFF_W-1:0] dx, dy;
   logic [HEAD_W-1:0] cordic_heading;
   cal_event_type cal_evt;
   cal_status_type cal_st;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign need_head = (req_kind == KIND_SAMPLE) && !cal_st.calibrating;
   assign load_rsp = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign dx = {req_mag_x[MAG_W-1], req_mag_x} - {cal_st.offset_x[MAG_W-1], cal_st.offset_x};
   assign dy = {req_mag_y[MAG_W-1], req_mag_y} - {cal_st.offset_y[MAG_W-1], cal_st.offset_y};

   assign cal_evt.load = accept;
   assign cal_evt.kind = req_kind;
   assign cal_evt.mag_x = req_mag_x;
   assign cal_evt.mag_y = req_mag_y;

   hic_cal u_cal (
      .clock  (clock),
      .reset  (reset),
      .evt    (cal_evt),
      .status (cal_st)
   );

   hic_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && need_head),
      .dx      (dx),
      .dy      (dy),
      .done    (cordic_done),
      .heading (cordic_heading)
   );

   always_comb begin
      state_in = state_ff;
      hv_in = hv_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hv_in = need_head;
               state_in = need_head ? ST_RUN : ST_EMIT;
            end
         end
         ST_RUN: begin
            if (cordic_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (load_rsp) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ready);
      head_in = head_ff;
      hvalid_in = hvalid_ff;
      offx_in = offx_ff;
      offy_in = offy_ff;
      if (load_rsp) begin
         head_in = hv_ff ? cordic_heading : '0;
         hvalid_in = hv_ff;
         offx_in = cal_st.offset_x;
         offy_in = cal_st.offset_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hv_ff <= hv_in;
      head_ff <= head_in;
      hvalid_ff <= hvalid_in;
      offx_ff <= offx_in;
      offy_ff <= offy_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_heading_tenths = head_ff;
   assign rsp_heading_valid = hvalid_ff;
   assign rsp_offset_x_out = offx_ff;
   assign rsp_offset_y_out = offy_ff;

endmodule

@@ sv/hic_checker.sv @@
module hic_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_kind,
   input logic signed [hic_pkg::MAG_W-1:0]  req_mag_x,
   input logic signed [hic_pkg::MAG_W-1:0]  req_mag_y,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [hic_pkg::HEAD_W-1:0]        rsp_heading_tenths,
   input logic                              rsp_heading_valid,
   input logic signed [hic_pkg::MAG_W-1:0]  rsp_offset_x_out,
   input logic signed [hic_pkg::MAG_W-1:0]  rsp_offset_y_out
);
   import hic_pkg::*;

   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_heading_tenths <= HEAD_MAX))
      else $error("heading beyond full turn");

   a_no_head_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_heading_valid) |-> (rsp_heading_tenths == '0))
      else $error("heading nonzero without a valid heading");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_heading_tenths)
         && $stable(rsp_heading_valid)
         && $stable(rsp_offset_x_out) && $stable(rsp_offset_y_out)))
      else $error("stalled response changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_kind)
         && $stable(req_mag_x) && $stable(req_mag_y)))
      else $error("waiting request changed");

endmodule

bind compass_heading_hard_iron_cal_core hic_checker u_hic_checker (.*);
